FILE: design/popt_pkg.sv
// Shared constants, angle table and helpers for the point-on-path tester.
`timescale 1ns / 1ps
`default_nettype none
package popt_pkg;

    // default sizes
    localparam int MAX_SEGMENTS_DEF = 8;
    localparam int WORD_BITS_DEF    = 32;

    // table layout
    localparam int SEG_WORDS = 6;

    // arc flag threshold: 0.1 in Q16.16
    localparam int FLAG_LIMIT = 6553;

    // angle arithmetic
    localparam int ZW           = 24;
    localparam int CORDIC_STEPS = 17;
    localparam int NORM_SHIFT   = 40;
    localparam logic signed [ZW-1:0] PI_Q     = ZW'(205887);
    localparam logic signed [ZW-1:0] TWO_PI_Q = ZW'(411775);

    // multiplier digit size
    localparam int MUL_DIGIT = 16;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_WIDTH = 2'd1;

    // atan(2^-i) in Q16.16
    function automatic logic signed [ZW-1:0] atan_q(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:    r = ZW'(51472);
            5'd1:    r = ZW'(30386);
            5'd2:    r = ZW'(16055);
            5'd3:    r = ZW'(8150);
            5'd4:    r = ZW'(4091);
            5'd5:    r = ZW'(2047);
            5'd6:    r = ZW'(1024);
            5'd7:    r = ZW'(512);
            5'd8:    r = ZW'(256);
            5'd9:    r = ZW'(128);
            5'd10:   r = ZW'(64);
            5'd11:   r = ZW'(32);
            5'd12:   r = ZW'(16);
            5'd13:   r = ZW'(8);
            5'd14:   r = ZW'(4);
            5'd15:   r = ZW'(2);
            5'd16:   r = ZW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/popt_seg_mem.sv
// Segment table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module popt_seg_mem #(
    parameter int W     = popt_pkg::WORD_BITS_DEF,
    parameter int DEPTH = popt_pkg::MAX_SEGMENTS_DEF * popt_pkg::SEG_WORDS,
    parameter int ADW   = $clog2(DEPTH)
) (
    input  wire logic           clk,
    input  wire logic           we,
    input  wire logic [ADW-1:0] waddr,
    input  wire logic [W-1:0]   wdata,
    input  wire logic           re,
    input  wire logic [ADW-1:0] raddr,
    output logic [W-1:0]        rdata
);

    logic [W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: design/popt_mul.sv
// Signed sequential multiplier, one 16-bit digit of the multiplier per cycle.
`timescale 1ns / 1ps
`default_nettype none
module popt_mul #(
    parameter int MW = 35,
    parameter int PW = 70
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [MW-1:0] a,
    input  wire logic signed [MW-1:0] b,
    output logic                      done,
    output logic signed [PW-1:0]      prod
);

    localparam int DG  = popt_pkg::MUL_DIGIT;
    localparam int ND  = (MW + DG - 1) / DG;
    localparam int BW  = ND * DG;
    localparam int CTW = $clog2(ND + 1);

    logic              run_reg;
    logic              done_reg;
    logic [CTW-1:0]    cnt_reg;
    logic [MW-1:0]     am_reg;
    logic [BW-1:0]     bm_reg;
    logic [PW-1:0]     acc_reg;
    logic              neg_reg;
    logic signed [PW-1:0] prod_reg;

    logic [MW-1:0]     am_next;
    logic [MW-1:0]     bm_abs;
    logic [DG-1:0]     digit;
    logic [MW+DG-1:0]  pp;
    logic [PW-1:0]     acc_next;

    // operand magnitudes and one digit step
    always_comb
    begin
        am_next  = a[MW-1] ? MW'(-a) : MW'(a);
        bm_abs   = b[MW-1] ? MW'(-b) : MW'(b);
        digit    = bm_reg[BW-1 -: DG];
        pp       = am_reg * digit;
        acc_next = (acc_reg << DG) + PW'(pp);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CTW'(ND);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // datapath, most significant digit first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            am_reg  <= am_next;
            bm_reg  <= BW'(bm_abs);
            acc_reg <= '0;
            neg_reg <= a[MW-1] ^ b[MW-1];
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                prod_reg <= neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
            end
            else
            begin
                acc_reg <= acc_next;
                bm_reg  <= bm_reg << DG;
            end
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule
`default_nettype wire

FILE: design/popt_cordic.sv
// Iterative CORDIC vectoring unit: angle of (x,y) in Q16.16 radians.
`timescale 1ns / 1ps
`default_nettype none
module popt_cordic #(
    parameter int IW = 35,
    parameter int CR = 45
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [IW-1:0]              x,
    input  wire logic signed [IW-1:0]              y,
    output logic                                   done,
    output logic signed [popt_pkg::ZW-1:0]         z
);

    localparam int ZW = popt_pkg::ZW;
    localparam logic signed [CR-1:0] LIM = CR'(longint'(1) <<< popt_pkg::NORM_SHIFT);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_NORM = 3'b010,
        C_ROT  = 3'b100
    } cor_state_t;

    cor_state_t           state_reg;
    logic                 done_reg;
    logic [4:0]           i_reg;
    logic signed [CR-1:0] x_reg;
    logic signed [CR-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;

    logic signed [CR-1:0] xe;
    logic signed [CR-1:0] ye;
    logic signed [CR-1:0] xs;
    logic signed [CR-1:0] ys;
    logic                 below_lim;
    logic                 zero_in;

    always_comb
    begin
        xe        = CR'(x);
        ye        = CR'(y);
        xs        = x_reg >>> i_reg;
        ys        = y_reg >>> i_reg;
        below_lim = (x_reg < LIM) && (x_reg > -LIM) && (y_reg < LIM) && (y_reg > -LIM);
        zero_in   = (x == '0) && (y == '0);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        if (zero_in)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= C_NORM;
                        end
                    end
                end
                C_NORM:
                begin
                    if (!below_lim)
                    begin
                        state_reg <= C_ROT;
                        i_reg     <= '0;
                    end
                end
                C_ROT:
                begin
                    if (i_reg == 5'(popt_pkg::CORDIC_STEPS - 1))
                    begin
                        state_reg <= C_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    if (zero_in)
                    begin
                        z_reg <= '0;
                    end
                    else if (x[IW-1])
                    begin
                        // left half plane: rotate by pi first
                        x_reg <= -xe;
                        y_reg <= -ye;
                        z_reg <= y[IW-1] ? -popt_pkg::PI_Q : popt_pkg::PI_Q;
                    end
                    else
                    begin
                        x_reg <= xe;
                        y_reg <= ye;
                        z_reg <= '0;
                    end
                end
            end
            C_NORM:
            begin
                if (below_lim)
                begin
                    x_reg <= x_reg <<< 1;
                    y_reg <= y_reg <<< 1;
                end
            end
            C_ROT:
            begin
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + popt_pkg::atan_q(i_reg);
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - popt_pkg::atan_q(i_reg);
                end
            end
            default:
            begin
                z_reg <= z_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign z    = z_reg;

endmodule
`default_nettype wire

FILE: design/point_on_path_test_top.sv
// Point-on-path tester top level: segment table, query sequencer, config.
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+-------------------------
//  item in   | kind seg_index value_slot value cursor_x/y     | start & !busy
//            | offset_x offset_y                              |
//  result    | on_path                                        | done, one cycle, no stall
//  config    | cfg_we cfg_index cfg_data                      | cfg_we, single cycle
//
// A table write goes into the memory as it is accepted. A query walks the
// active segments one at a time: a fetch of the six segment words and a
// setup step, then 3 multiplier jobs for a line or 4 for an arc, then for
// arcs that pass the radius test two CORDIC runs (normalising doublings, 17
// rotations, start and finish); a final step registers the result.
// After reset a clearing pass zeroes all MAX_SEGMENTS*6 table words while
// busy is high. The result beat cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none
module point_on_path_test_top #(
    parameter int MAX_SEGMENTS = popt_pkg::MAX_SEGMENTS_DEF,
    parameter int WORD_BITS    = popt_pkg::WORD_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            kind,
    input  wire logic [2:0]                      seg_index,
    input  wire logic [2:0]                      value_slot,
    input  wire logic signed [31:0]              value,
    input  wire logic signed [31:0]              cursor_x,
    input  wire logic signed [31:0]              cursor_y,
    input  wire logic signed [31:0]              offset_x,
    input  wire logic signed [31:0]              offset_y,
    output logic                                 done,
    output logic                                 on_path,
    input  wire logic                            cfg_we,
    input  wire logic [popt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [30:0]                     cfg_data
);

    localparam int XW    = (WORD_BITS > 32) ? WORD_BITS : 32;
    localparam int MW    = XW + 3;
    localparam int PW    = 2 * MW;
    localparam int CR    = ((MW > 42) ? MW : 42) + 3;
    localparam int AW    = WORD_BITS + 4;
    localparam int ZW    = popt_pkg::ZW;
    localparam int SW    = popt_pkg::SEG_WORDS;
    localparam int DEPTH = MAX_SEGMENTS * SW;
    localparam int ADW   = $clog2(DEPTH);
    localparam int CNTW  = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CLEAR = 10'b0000000010,
        S_FETCH = 10'b0000000100,
        S_PREP  = 10'b0000001000,
        S_MUL   = 10'b0000010000,
        S_CHK   = 10'b0000100000,
        S_ANG   = 10'b0001000000,
        S_FIN   = 10'b0010000000,
        S_NEXT  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [CNTW-1:0] cnt_reg;
    logic [30:0]     pw_reg;

    // query operands
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] ox_reg;
    logic signed [31:0] oy_reg;

    // sequencing
    logic [CNTW-1:0] seg_reg;
    logic [ADW-1:0]  base_reg;
    logic [ADW-1:0]  clr_reg;
    logic [2:0]      wc_reg;
    logic            pend_reg;
    logic [2:0]      pslot_reg;
    logic [1:0]      jcnt_reg;
    logic            mrun_reg;
    logic            cj_reg;
    logic            crun_reg;
    logic            hit_reg;
    logic            done_reg;
    logic            on_path_reg;

    // segment words and derived values
    logic signed [WORD_BITS-1:0] w_reg [SW];
    logic signed [MW-1:0] x0p_reg;
    logic signed [MW-1:0] y0p_reg;
    logic signed [MW-1:0] x1p_reg;
    logic signed [MW-1:0] y1p_reg;
    logic signed [MW-1:0] dx_reg;
    logic signed [MW-1:0] dy_reg;
    logic signed [MW-1:0] u_reg;
    logic signed [MW-1:0] v_reg;
    logic signed [MW-1:0] hi_reg;
    logic signed [MW-1:0] lo_reg;
    logic                 arc_reg;
    logic signed [PW-1:0] p_reg [4];
    logic signed [ZW-1:0] za_reg;
    logic signed [ZW-1:0] zs_reg;

    // memory ports
    logic                 mem_we;
    logic [ADW-1:0]       mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [ADW-1:0]       mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    // unit ports
    logic                 mul_start;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic                 mul_done;
    logic signed [PW-1:0] mul_prod;
    logic                 cor_start;
    logic signed [MW-1:0] cor_x;
    logic signed [MW-1:0] cor_y;
    logic                 cor_done;
    logic signed [ZW-1:0] cor_z;

    logic accept;
    logic wr_ok;
    logic [1:0] jlast;

    logic signed [MW-1:0] eps_s;
    logic signed [MW-1:0] h_s;
    logic signed [MW-1:0] cx_e;
    logic signed [MW-1:0] cy_e;
    logic signed [MW-1:0] absdx;
    logic signed [MW-1:0] absr;
    logic signed [MW-1:0] x1c;
    logic signed [MW-1:0] absx1c;
    logic                 xspan;
    logic                 yspan;
    logic signed [PW:0]   dres;
    logic signed [PW:0]   absd;
    logic signed [PW:0]   sq;
    logic                 line_hit;
    logic                 rpass;
    logic signed [AW-1:0] ang_a;
    logic signed [AW-1:0] ang_s;
    logic signed [AW-1:0] ang_e0;
    logic signed [AW-1:0] ang_e1;
    logic signed [AW-1:0] ang_e;
    logic signed [AW-1:0] ang_sl;
    logic                 ang_hit;
    logic [31:0]          cfg_n;

    assign accept = start && (state_reg == S_IDLE);
    assign wr_ok  = (32'(seg_index) < 32'(MAX_SEGMENTS)) && (32'(value_slot) < 32'(SW));

    // table memory ports: writes from the clearing pass or a write beat, reads during fetch
    always_comb
    begin
        mem_we    = (state_reg == S_CLEAR) || (accept && !kind && wr_ok);
        mem_waddr = (state_reg == S_CLEAR) ? clr_reg
                  : ADW'(32'(seg_index) * 32'(SW) + 32'(value_slot));
        mem_wdata = (state_reg == S_CLEAR) ? '0 : WORD_BITS'(value);
        mem_re    = (state_reg == S_FETCH) && (wc_reg < 3'(SW));
        mem_raddr = base_reg + ADW'(wc_reg);
    end

    popt_seg_mem #(
        .W     (WORD_BITS),
        .DEPTH (DEPTH),
        .ADW   (ADW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // tolerances and common extensions
    always_comb
    begin
        eps_s  = $signed(MW'(pw_reg[30:1]));
        h_s    = $signed(MW'(pw_reg[30:2]));
        cx_e   = MW'(cx_reg);
        cy_e   = MW'(cy_reg);
        absdx  = dx_reg[MW-1] ? -dx_reg : dx_reg;
        absr   = MW'(w_reg[2]) < 0 ? -MW'(w_reg[2]) : MW'(w_reg[2]);
        jlast  = arc_reg ? 2'd3 : 2'd2;
    end

    // multiplier job select
    always_comb
    begin
        mul_start = (state_reg == S_MUL) && !mrun_reg;
        if (arc_reg)
        begin
            case (jcnt_reg)
                2'd0:    begin mul_a = u_reg;  mul_b = u_reg;  end
                2'd1:    begin mul_a = v_reg;  mul_b = v_reg;  end
                2'd2:    begin mul_a = hi_reg; mul_b = hi_reg; end
                default: begin mul_a = lo_reg; mul_b = lo_reg; end
            endcase
        end
        else
        begin
            case (jcnt_reg)
                2'd0:    begin mul_a = v_reg;  mul_b = dx_reg; end
                2'd1:    begin mul_a = dy_reg; mul_b = u_reg;  end
                default: begin mul_a = eps_s;  mul_b = absdx;  end
            endcase
        end
    end

    popt_mul #(
        .MW (MW),
        .PW (PW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // angle jobs: cursor angle, then slack angle
    always_comb
    begin
        cor_start = (state_reg == S_ANG) && !crun_reg;
        cor_x     = cj_reg ? absr : u_reg;
        cor_y     = cj_reg ? eps_s : v_reg;
    end

    popt_cordic #(
        .IW (MW),
        .CR (CR)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .x     (cor_x),
        .y     (cor_y),
        .done  (cor_done),
        .z     (cor_z)
    );

    // line and radius tests
    always_comb
    begin
        x1c    = x1p_reg - cx_e;
        absx1c = x1c[MW-1] ? -x1c : x1c;
        yspan  = ((y1p_reg + h_s > cy_e) && (y0p_reg - h_s < cy_e))
              || ((y0p_reg + h_s > cy_e) && (y1p_reg - h_s < cy_e));
        xspan  = ((x1p_reg + h_s > cx_e) && (x0p_reg - h_s < cx_e))
              || ((x0p_reg + h_s > cx_e) && (x1p_reg - h_s < cx_e));
        dres   = (PW+1)'(p_reg[0]) - (PW+1)'(p_reg[1]);
        absd   = dres[PW] ? -dres : dres;
        if (absdx < eps_s)
        begin
            line_hit = (absx1c < eps_s) && yspan;
        end
        else
        begin
            line_hit = (absd < (PW+1)'(p_reg[2])) && xspan;
        end
        sq    = (PW+1)'(p_reg[0]) + (PW+1)'(p_reg[1]);
        rpass = (hi_reg > 0) && (sq < (PW+1)'(p_reg[2]))
             && ((lo_reg < 0) || ((PW+1)'(p_reg[3]) < sq));
    end

    // angle window test
    always_comb
    begin
        ang_a  = (za_reg <= 0) ? AW'(za_reg) + AW'(popt_pkg::TWO_PI_Q) : AW'(za_reg);
        ang_s  = (w_reg[3] <= 0) ? AW'(w_reg[3]) + AW'(popt_pkg::TWO_PI_Q) : AW'(w_reg[3]);
        ang_e0 = AW'(w_reg[3]) + AW'(w_reg[4]);
        ang_e1 = (ang_e0 <= 0) ? ang_e0 + AW'(popt_pkg::TWO_PI_Q) : ang_e0;
        ang_e  = (ang_e1 >= AW'(popt_pkg::TWO_PI_Q)) ? ang_e1 - AW'(popt_pkg::TWO_PI_Q)
                                                      : ang_e1;
        ang_sl = zs_reg[ZW-1] ? -AW'(zs_reg) : AW'(zs_reg);
        ang_hit = ((ang_a > ang_s - ang_sl) && (ang_a < ang_e + ang_sl))
               || ((ang_a < ang_s + ang_sl) && (ang_a > ang_e - ang_sl));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept && kind) state_next = S_FETCH;
            S_CLEAR: if (clr_reg == ADW'(DEPTH - 1)) state_next = S_IDLE;
            S_FETCH: if (wc_reg == 3'(SW)) state_next = S_PREP;
            S_PREP:  state_next = S_MUL;
            S_MUL:   if (mul_done && mrun_reg && (jcnt_reg == jlast)) state_next = S_CHK;
            S_CHK:
            begin
                if (arc_reg && rpass)
                begin
                    state_next = S_ANG;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_ANG:   if (cor_done && crun_reg && cj_reg) state_next = S_FIN;
            S_FIN:   state_next = S_NEXT;
            S_NEXT:
            begin
                if ((32'(seg_reg) + 32'd1) >= 32'(cnt_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // configuration count clamp
    always_comb
    begin
        cfg_n = 32'(cfg_data[3:0]);
        if (cfg_n < 32'd1)
        begin
            cfg_n = 32'd1;
        end
        if (cfg_n > 32'(MAX_SEGMENTS))
        begin
            cfg_n = 32'(MAX_SEGMENTS);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= CNTW'(1);
            pw_reg      <= 31'd65536;
            clr_reg     <= '0;
            seg_reg     <= '0;
            base_reg    <= '0;
            wc_reg      <= '0;
            pend_reg    <= 1'b0;
            jcnt_reg    <= '0;
            mrun_reg    <= 1'b0;
            cj_reg      <= 1'b0;
            crun_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
            on_path_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DONE);

            if (cfg_we && (cfg_index == popt_pkg::CFG_SEG_COUNT))
            begin
                cnt_reg <= CNTW'(cfg_n);
            end
            if (cfg_we && (cfg_index == popt_pkg::CFG_PATH_WIDTH))
            begin
                pw_reg <= cfg_data;
            end

            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end

            pend_reg <= mem_re;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept && kind)
                    begin
                        seg_reg  <= '0;
                        base_reg <= '0;
                        wc_reg   <= '0;
                        hit_reg  <= 1'b0;
                    end
                end
                S_FETCH:
                begin
                    if (wc_reg < 3'(SW))
                    begin
                        wc_reg <= wc_reg + 1'b1;
                    end
                end
                S_PREP:
                begin
                    jcnt_reg <= '0;
                    mrun_reg <= 1'b0;
                end
                S_MUL:
                begin
                    if (mul_start)
                    begin
                        mrun_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        mrun_reg <= 1'b0;
                        jcnt_reg <= jcnt_reg + 1'b1;
                    end
                end
                S_CHK:
                begin
                    cj_reg   <= 1'b0;
                    crun_reg <= 1'b0;
                    if (!arc_reg)
                    begin
                        hit_reg <= hit_reg | line_hit;
                    end
                end
                S_ANG:
                begin
                    if (cor_start)
                    begin
                        crun_reg <= 1'b1;
                    end
                    else if (cor_done)
                    begin
                        crun_reg <= 1'b0;
                        cj_reg   <= 1'b1;
                    end
                end
                S_FIN:
                begin
                    hit_reg <= hit_reg | ang_hit;
                end
                S_NEXT:
                begin
                    if (state_next == S_FETCH)
                    begin
                        seg_reg  <= seg_reg + 1'b1;
                        base_reg <= base_reg + ADW'(SW);
                        wc_reg   <= '0;
                    end
                end
                S_DONE:
                begin
                    on_path_reg <= hit_reg;
                end
                default:
                begin
                    hit_reg <= hit_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept && kind)
        begin
            cx_reg <= cursor_x;
            cy_reg <= cursor_y;
            ox_reg <= offset_x;
            oy_reg <= offset_y;
        end

        pslot_reg <= wc_reg;
        if (pend_reg)
        begin
            w_reg[pslot_reg] <= mem_rdata;
        end

        if (state_reg == S_PREP)
        begin
            x0p_reg <= MW'(w_reg[0]) + MW'(ox_reg);
            y0p_reg <= MW'(w_reg[1]) + MW'(oy_reg);
            x1p_reg <= MW'(w_reg[2]) + MW'(ox_reg);
            y1p_reg <= MW'(w_reg[3]) + MW'(oy_reg);
            dx_reg  <= MW'(w_reg[2]) - MW'(w_reg[0]);
            dy_reg  <= MW'(w_reg[3]) - MW'(w_reg[1]);
            u_reg   <= cx_e - MW'(w_reg[0]) - MW'(ox_reg);
            v_reg   <= cy_e - MW'(w_reg[1]) - MW'(oy_reg);
            hi_reg  <= MW'(w_reg[2]) + eps_s;
            lo_reg  <= MW'(w_reg[2]) - eps_s;
            arc_reg <= MW'(w_reg[5]) > MW'(popt_pkg::FLAG_LIMIT);
        end

        if ((state_reg == S_MUL) && mul_done && mrun_reg)
        begin
            p_reg[jcnt_reg] <= mul_prod;
        end

        if ((state_reg == S_ANG) && cor_done && crun_reg)
        begin
            if (cj_reg)
            begin
                zs_reg <= cor_z;
            end
            else
            begin
                za_reg <= cor_z;
            end
        end
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign on_path = on_path_reg;

    // a result beat only follows a query in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a query in flight");

    // an accepted query always makes the block busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind) |=> busy)
        else $error("accepted query did not start");

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

endmodule
`default_nettype wire
